// ===== sv/sabp_pkg.sv =====
// Package for the sRGB alpha-blend pixel pipeline: widths, word types and constant tables.
`default_nettype none

package sabp_pkg;

    localparam int FRAC_BITS = 12;
    localparam int SRC_W     = 13;
    localparam int PIX_W     = 32;
    localparam int CODE_W    = 8;
    localparam int NUM_CODES = 1 << CODE_W;
    localparam int NUM_CH    = 4;
    localparam int Q_BITS    = 16;
    localparam int LIN_W     = Q_BITS + 1;
    localparam int WIDEN     = Q_BITS - FRAC_BITS;
    localparam int S_W       = SRC_W + WIDEN;
    localparam int W_W       = S_W + 1;
    localparam int P_W       = 2 * S_W;
    localparam int DP_W      = LIN_W + 1 + W_W;
    localparam int SUM_W     = DP_W + 1;
    localparam int K_FULL    = 255;
    localparam int KPROD_W   = SRC_W + CODE_W;
    localparam int K_W       = KPROD_W - FRAC_BITS;
    localparam int ENC_SCALE = 4095;
    localparam int ENC_IDX_W = 12;
    localparam int SEG_START = 1008;
    localparam int SEG_SHIFT = 4;

    // channel order matches the byte order of a packed pixel, low to high
    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;
    localparam int CH_A = 3;

    localparam logic [LIN_W-1:0] ONE_Q16 = LIN_W'(1) << Q_BITS;

    typedef logic [LIN_W-1:0]     dec_tab_t [NUM_CODES];
    typedef logic [ENC_IDX_W-1:0] thr_tab_t [NUM_CODES];

    typedef struct packed {
        logic [NUM_CH-1:0][S_W-1:0]   src;
        logic [NUM_CH-1:0][LIN_W-1:0] dst_lin;
        logic                         direct;
        logic                         bypass;
        logic [PIX_W-1:0]             dst;
    } dec_word_t;

    typedef struct packed {
        logic [NUM_CH-1:0][LIN_W-1:0] val;
        logic                         bypass;
        logic [PIX_W-1:0]             dst;
    } mix_word_t;

    function automatic longint unsigned pow5_q30(input longint unsigned y);
        longint unsigned p;
        p = y;
        for (int i = 0; i < 4; i++)
        begin
            p = (p * y) >> 30;
        end
        return p;
    endfunction

    // sRGB code to linear light, Q30
    function automatic longint unsigned lin_q30(input int unsigned c);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (c <= 10)
        begin
            return (64'(c) * 64'd100 << 30) / 64'd329460;
        end
        t  = (64'(c * 1000 + 14025) << 30) / 64'd269025;
        t2 = (t * t) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        for (int it = 0; it < 32; it++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                if (pow5_q30(mid) <= t2)
                    lo = mid;
                else
                    hi = mid - 1;
            end
        end
        return (t2 * lo) >> 30;
    endfunction

    function automatic dec_tab_t build_srgb_dec();
        dec_tab_t tab;
        for (int c = 0; c < NUM_CODES; c++)
        begin
            tab[c] = LIN_W'((lin_q30(c) + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    function automatic dec_tab_t build_lin_dec();
        dec_tab_t tab;
        for (int c = 0; c < NUM_CODES; c++)
        begin
            tab[c] = LIN_W'((64'(c) * 64'd65536 + 64'd127) / 64'd255);
        end
        return tab;
    endfunction

    // smallest encoder sample at which each code is reached
    function automatic thr_tab_t build_srgb_thr();
        thr_tab_t tab;
        for (int c = 0; c < NUM_CODES; c++)
        begin
            tab[c] = ENC_IDX_W'((lin_q30(c) * 64'(ENC_SCALE) + (64'd1 << 30) - 64'd1) >> 30);
        end
        return tab;
    endfunction

    localparam dec_tab_t SRGB_DEC = build_srgb_dec();
    localparam dec_tab_t LIN_DEC  = build_lin_dec();
    localparam thr_tab_t SRGB_THR = build_srgb_thr();

endpackage

`default_nettype wire

// ===== sv/sabp_decode.sv =====
// Decode stage: destination bytes to Q16 linear, source widening, bypass and direct flags.
`default_nettype none

module sabp_decode (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   linear_mode,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [sabp_pkg::PIX_W-1:0]             dst_pixel,
    input  logic [sabp_pkg::SRC_W-1:0]             src_red,
    input  logic [sabp_pkg::SRC_W-1:0]             src_green,
    input  logic [sabp_pkg::SRC_W-1:0]             src_blue,
    input  logic [sabp_pkg::SRC_W-1:0]             src_alpha,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output sabp_pkg::dec_word_t                    out_word
);

    logic                                                    valid_reg;
    logic                                                    load;
    sabp_pkg::dec_word_t                                     word_reg;
    sabp_pkg::dec_word_t                                     word_next;
    logic [sabp_pkg::NUM_CH-1:0][sabp_pkg::CODE_W-1:0]       dst_code;
    logic [sabp_pkg::NUM_CH-1:0][sabp_pkg::SRC_W-1:0]        src_in;
    logic [sabp_pkg::KPROD_W-1:0]                            k_prod;
    logic [sabp_pkg::K_W-1:0]                                k;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;
    assign dst_code = dst_pixel;
    assign src_in   = {src_alpha, src_red, src_green, src_blue};

    always_comb
    begin
        k_prod = sabp_pkg::KPROD_W'(src_alpha) * sabp_pkg::KPROD_W'(sabp_pkg::K_FULL);
        k      = sabp_pkg::K_W'(k_prod >> sabp_pkg::FRAC_BITS);
        for (int ch = 0; ch < sabp_pkg::NUM_CH; ch++)
        begin
            word_next.src[ch] = sabp_pkg::S_W'(src_in[ch]) << sabp_pkg::WIDEN;
            if (ch == sabp_pkg::CH_A || linear_mode)
                word_next.dst_lin[ch] = sabp_pkg::LIN_DEC[dst_code[ch]];
            else
                word_next.dst_lin[ch] = sabp_pkg::SRGB_DEC[dst_code[ch]];
        end
        word_next.bypass = (k == sabp_pkg::K_W'(0));
        word_next.direct = (k == sabp_pkg::K_W'(sabp_pkg::K_FULL));
        word_next.dst    = dst_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== sv/sabp_mix.sv =====
// Blend stages: weighted products, then sum, floor, clamp to [0, 1].
`default_nettype none

module sabp_mix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sabp_pkg::dec_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sabp_pkg::mix_word_t  out_word
);

    localparam int Q_HI_W = sabp_pkg::SUM_W - 1 - sabp_pkg::Q_BITS;
    localparam logic [sabp_pkg::S_W-1:0] ONE_S = sabp_pkg::S_W'(1) << sabp_pkg::Q_BITS;

    logic                                                   v1_reg;
    logic                                                   v2_reg;
    logic                                                   load1;
    logic                                                   load2;
    logic        [sabp_pkg::NUM_CH-1:0][sabp_pkg::P_W-1:0]  ps_reg;
    logic        [sabp_pkg::NUM_CH-1:0][sabp_pkg::P_W-1:0]  ps_next;
    logic signed [sabp_pkg::DP_W-1:0]                       pd_reg  [sabp_pkg::NUM_CH];
    logic signed [sabp_pkg::DP_W-1:0]                       pd_next [sabp_pkg::NUM_CH];
    logic        [sabp_pkg::NUM_CH-1:0][sabp_pkg::LIN_W-1:0] sc_reg;
    logic        [sabp_pkg::NUM_CH-1:0][sabp_pkg::LIN_W-1:0] sc_next;
    logic                                                   direct_reg;
    logic                                                   bypass_reg;
    logic        [sabp_pkg::PIX_W-1:0]                      dst_reg;
    logic signed [sabp_pkg::W_W-1:0]                        w;
    logic        [sabp_pkg::S_W-1:0]                        a;
    logic signed [sabp_pkg::SUM_W-1:0]                      sum [sabp_pkg::NUM_CH];
    logic        [Q_HI_W-1:0]                               q   [sabp_pkg::NUM_CH];
    sabp_pkg::mix_word_t                                    word_reg;
    sabp_pkg::mix_word_t                                    word_next;

    assign load2    = !v2_reg || out_ready;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    always_comb
    begin
        a = in_word.src[sabp_pkg::CH_A];
        w = $signed({1'b0, ONE_S}) - $signed({1'b0, a});
        for (int ch = 0; ch < sabp_pkg::NUM_CH; ch++)
        begin
            ps_next[ch] = sabp_pkg::P_W'(in_word.src[ch]) * sabp_pkg::P_W'(a);
            pd_next[ch] = sabp_pkg::DP_W'($signed({1'b0, in_word.dst_lin[ch]}))
                        * sabp_pkg::DP_W'(w);
            if (in_word.src[ch] > sabp_pkg::S_W'(sabp_pkg::ONE_Q16))
                sc_next[ch] = sabp_pkg::ONE_Q16;
            else
                sc_next[ch] = sabp_pkg::LIN_W'(in_word.src[ch]);
        end
    end

    always_comb
    begin
        word_next.bypass = bypass_reg;
        word_next.dst    = dst_reg;
        for (int ch = 0; ch < sabp_pkg::NUM_CH; ch++)
        begin
            sum[ch] = sabp_pkg::SUM_W'(pd_reg[ch])
                    + $signed({{(sabp_pkg::SUM_W - sabp_pkg::P_W){1'b0}}, ps_reg[ch]});
            q[ch]   = sum[ch][sabp_pkg::SUM_W-2:sabp_pkg::Q_BITS];
            if (direct_reg)
                word_next.val[ch] = sc_reg[ch];
            else if (sum[ch][sabp_pkg::SUM_W-1])
                word_next.val[ch] = '0;
            else if (q[ch] > Q_HI_W'(sabp_pkg::ONE_Q16))
                word_next.val[ch] = sabp_pkg::ONE_Q16;
            else
                word_next.val[ch] = sabp_pkg::LIN_W'(q[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= in_valid;
            if (load2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            ps_reg     <= ps_next;
            pd_reg     <= pd_next;
            sc_reg     <= sc_next;
            direct_reg <= in_word.direct;
            bypass_reg <= in_word.bypass;
            dst_reg    <= in_word.dst;
        end
        if (load2)
            word_reg <= word_next;
    end

    assign out_valid = v2_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== sv/sabp_encode.sv =====
// Encode stages: scaling to byte or encoder sample, sRGB code search, pixel packing.
`default_nettype none

module sabp_encode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          linear_mode,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sabp_pkg::mix_word_t           in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sabp_pkg::PIX_W-1:0]    out_pixel
);

    localparam int NUM_COL     = sabp_pkg::NUM_CH - 1;
    localparam int SRCH_STAGES = 4;
    localparam int STEPS       = sabp_pkg::CODE_W / SRCH_STAGES;
    localparam int NUM_STG     = SRCH_STAGES + 1;
    localparam int M8_W        = sabp_pkg::LIN_W + sabp_pkg::CODE_W;
    localparam int M12_W       = sabp_pkg::LIN_W + sabp_pkg::ENC_IDX_W;

    typedef struct packed {
        logic [NUM_COL-1:0][sabp_pkg::ENC_IDX_W-1:0]        x;
        logic [NUM_COL-1:0][sabp_pkg::CODE_W-1:0]           idx;
        logic [sabp_pkg::NUM_CH-1:0][sabp_pkg::CODE_W-1:0]  lin_code;
        logic                                               mode;
        logic                                               bypass;
        logic [sabp_pkg::PIX_W-1:0]                         dst;
    } srch_t;

    function automatic logic [sabp_pkg::CODE_W-1:0] search_step(
        input logic [sabp_pkg::CODE_W-1:0]    idx,
        input logic [sabp_pkg::ENC_IDX_W-1:0] x,
        input int                             bitpos
    );
        logic [sabp_pkg::CODE_W-1:0] cand;
        cand = idx | (sabp_pkg::CODE_W'(1) << bitpos);
        return (sabp_pkg::SRGB_THR[cand] <= x) ? cand : idx;
    endfunction

    logic [NUM_STG-1:0]                                   valid_reg;
    logic [NUM_STG-1:0]                                   load;
    srch_t                                                stg_reg   [SRCH_STAGES];
    srch_t                                                srch_next [SRCH_STAGES];
    srch_t                                                e_next;
    logic [sabp_pkg::PIX_W-1:0]                           pixel_reg;
    logic [sabp_pkg::PIX_W-1:0]                           pixel_next;
    logic [sabp_pkg::NUM_CH-1:0][sabp_pkg::CODE_W-1:0]    packed_code;
    logic [M8_W-1:0]                                      m255;
    logic [M12_W-1:0]                                     m4095;
    logic [sabp_pkg::ENC_IDX_W-1:0]                       n;
    logic [sabp_pkg::CODE_W-1:0]                          idx_t;

    always_comb
    begin
        load[NUM_STG-1] = !valid_reg[NUM_STG-1] || out_ready;
        for (int k = NUM_STG - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign in_ready = load[0];

    always_comb
    begin
        m255  = '0;
        m4095 = '0;
        n     = '0;
        e_next.mode   = linear_mode;
        e_next.bypass = in_word.bypass;
        e_next.dst    = in_word.dst;
        e_next.idx    = '0;
        for (int ch = 0; ch < sabp_pkg::NUM_CH; ch++)
        begin
            m255 = M8_W'(in_word.val[ch]) * M8_W'(sabp_pkg::K_FULL);
            e_next.lin_code[ch] = m255[sabp_pkg::Q_BITS +: sabp_pkg::CODE_W];
        end
        for (int ch = 0; ch < NUM_COL; ch++)
        begin
            m4095 = M12_W'(in_word.val[ch]) * M12_W'(sabp_pkg::ENC_SCALE);
            n     = m4095[sabp_pkg::Q_BITS +: sabp_pkg::ENC_IDX_W];
            if (n < sabp_pkg::ENC_IDX_W'(sabp_pkg::SEG_START))
                e_next.x[ch] = n;
            else
                e_next.x[ch] = (n >> sabp_pkg::SEG_SHIFT) << sabp_pkg::SEG_SHIFT;
        end
    end

    // two code bits resolved per stage, high bits first
    always_comb
    begin
        idx_t = '0;
        for (int s = 0; s < SRCH_STAGES; s++)
        begin
            srch_next[s] = stg_reg[s];
            for (int ch = 0; ch < NUM_COL; ch++)
            begin
                idx_t = stg_reg[s].idx[ch];
                for (int j = 0; j < STEPS; j++)
                begin
                    idx_t = search_step(idx_t, stg_reg[s].x[ch],
                                        sabp_pkg::CODE_W - 1 - s * STEPS - j);
                end
                srch_next[s].idx[ch] = idx_t;
            end
        end
    end

    always_comb
    begin
        packed_code[sabp_pkg::CH_A] = srch_next[SRCH_STAGES-1].lin_code[sabp_pkg::CH_A];
        for (int ch = 0; ch < NUM_COL; ch++)
        begin
            if (srch_next[SRCH_STAGES-1].mode)
                packed_code[ch] = srch_next[SRCH_STAGES-1].lin_code[ch];
            else
                packed_code[ch] = srch_next[SRCH_STAGES-1].idx[ch];
        end
        if (srch_next[SRCH_STAGES-1].bypass)
            pixel_next = srch_next[SRCH_STAGES-1].dst;
        else
            pixel_next = packed_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (load[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NUM_STG; k++)
            begin
                if (load[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            stg_reg[0] <= e_next;
        for (int s = 1; s < SRCH_STAGES; s++)
        begin
            if (load[s])
                stg_reg[s] <= srch_next[s-1];
        end
        if (load[NUM_STG-1])
            pixel_reg <= pixel_next;
    end

    assign out_valid = valid_reg[NUM_STG-1];
    assign out_pixel = pixel_reg;

endmodule

`default_nettype wire

// ===== sv/srgb_alpha_blend_pixel.sv =====
// Top level of the sRGB-correct alpha-blend pixel pipeline.
//
//  channel   handshake                signals
//  config    cfg_wr_en                cfg_wr_data (linear_mode)
//  input     in_valid / in_ready      dst_pixel, src_red, src_green, src_blue, src_alpha
//  output    out_valid / out_ready    out_pixel
//
// One word per clock in and out without stall; words go through decode, blend,
// encode, then code search and pack. The sRGB code search over the threshold table
// sets the depth. Reset clears all valid bits and linear_mode. Each stage holds its
// word under stall and takes a new one whenever it empties, so bubbles close up.
`default_nettype none

module srgb_alpha_blend_pixel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sabp_pkg::PIX_W-1:0]    dst_pixel,
    input  logic [sabp_pkg::SRC_W-1:0]    src_red,
    input  logic [sabp_pkg::SRC_W-1:0]    src_green,
    input  logic [sabp_pkg::SRC_W-1:0]    src_blue,
    input  logic [sabp_pkg::SRC_W-1:0]    src_alpha,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sabp_pkg::PIX_W-1:0]    out_pixel
);

    logic                 linear_mode_reg;
    logic                 dec_valid;
    logic                 dec_ready;
    sabp_pkg::dec_word_t  dec_word;
    logic                 mix_valid;
    logic                 mix_ready;
    sabp_pkg::mix_word_t  mix_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            linear_mode_reg <= 1'b0;
        else if (cfg_wr_en)
            linear_mode_reg <= cfg_wr_data;
    end

    sabp_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .linear_mode (linear_mode_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .dst_pixel   (dst_pixel),
        .src_red     (src_red),
        .src_green   (src_green),
        .src_blue    (src_blue),
        .src_alpha   (src_alpha),
        .out_valid   (dec_valid),
        .out_ready   (dec_ready),
        .out_word    (dec_word)
    );

    sabp_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_word   (dec_word),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_word  (mix_word)
    );

    sabp_encode u_encode (
        .clk         (clk),
        .rst_n       (rst_n),
        .linear_mode (linear_mode_reg),
        .in_valid    (mix_valid),
        .in_ready    (mix_ready),
        .in_word     (mix_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_pixel   (out_pixel)
    );

endmodule

`default_nettype wire

// ===== test/srgb_alpha_blend_pixel_test.sv =====
// Testbench for srgb_alpha_blend_pixel: random and directed blends checked against a blend model.
`timescale 1ns / 1ps

typedef struct {
    logic [sabp_pkg::PIX_W-1:0] dst;
    logic [sabp_pkg::SRC_W-1:0] red;
    logic [sabp_pkg::SRC_W-1:0] green;
    logic [sabp_pkg::SRC_W-1:0] blue;
    logic [sabp_pkg::SRC_W-1:0] alpha;
} blend_word_t;

class pixel_blend_checker;
    typedef logic [sabp_pkg::PIX_W-1:0] pixel_t;

    localparam longint ONE = 65536;
    localparam int SEG_BASE = 1008;
    localparam int ENC_LEN = 1201;

    longint unsigned code_to_light [256];
    byte unsigned light_to_code [ENC_LEN];
    bit linear_mode;
    pixel_t expected_pixels [$];
    int errors;

    function new();
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        longint unsigned smp;
        int cnt;
        linear_mode = 1'b0;
        errors = 0;
        // Q30 linear light per sRGB code
        for (int c = 0; c < 256; c++)
        begin
            if (c <= 10)
            begin
                t = 64'(c);
                code_to_light[c] = ((t * 100) << 30) / 329460;
            end
            else
            begin
                t = 64'(c * 1000 + 14025);
                t = (t << 30) / 269025;
                t2 = (t * t) >> 30;
                lo = 0;
                hi = 64'd1 << 30;
                while (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    p = mid;
                    repeat (4) p = (p * mid) >> 30;
                    if (p <= t2)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
                code_to_light[c] = (t2 * lo) >> 30;
            end
        end
        // encoder samples: fine steps below SEG_BASE, 16-step segments above
        for (int i = 0; i < ENC_LEN; i++)
        begin
            smp = 64'((i < SEG_BASE) ? i : 16 * (63 + i - SEG_BASE));
            cnt = 0;
            for (int c = 1; c < 256; c++)
            begin
                if (code_to_light[c] * 4095 <= (smp << 30))
                    cnt++;
            end
            light_to_code[i] = 8'(cnt);
        end
    endfunction

    function pixel_t blend_pixel(blend_word_t w);
        longint s [4];
        longint a;
        longint d;
        longint sum;
        longint r;
        longint n;
        longint b;
        int unsigned k;
        pixel_t pix;
        s[sabp_pkg::CH_R] = longint'(w.red);
        s[sabp_pkg::CH_G] = longint'(w.green);
        s[sabp_pkg::CH_B] = longint'(w.blue);
        s[sabp_pkg::CH_A] = longint'(w.alpha);
        for (int ch = 0; ch < 4; ch++)
            s[ch] = s[ch] << sabp_pkg::WIDEN;
        a = s[sabp_pkg::CH_A];
        k = (int'(w.alpha) * 255) >> sabp_pkg::FRAC_BITS;
        if (k == 0)
            return w.dst;
        for (int ch = 0; ch < 4; ch++)
        begin
            if (k == 255)
                r = s[ch];
            else
            begin
                b = longint'(w.dst[ch*8 +: 8]);
                if (ch == sabp_pkg::CH_A || linear_mode)
                    d = (b * ONE + 127) / 255;
                else
                    d = (code_to_light[b] + 8192) >> 14;
                sum = s[ch] * a + d * (ONE - a);
                r = (sum < 0) ? 0 : (sum >>> 16);
            end
            if (r < 0)
                r = 0;
            if (r > ONE)
                r = ONE;
            if (ch == sabp_pkg::CH_A || linear_mode)
                pix[ch*8 +: 8] = 8'((r * 255) >> 16);
            else
            begin
                n = (r * 4095) >> 16;
                pix[ch*8 +: 8] = light_to_code[(n < SEG_BASE) ? n : SEG_BASE + (n >> 4) - 63];
            end
        end
        return pix;
    endfunction

    task report(string msg);
        errors++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function void note_word(blend_word_t w);
        expected_pixels.push_back(blend_pixel(w));
    endfunction

    task check_word(pixel_t got);
        pixel_t want;
        if (expected_pixels.size() == 0)
            report($sformatf("out_pixel %h with nothing pending", got));
        else
        begin
            want = expected_pixels.pop_front();
            if (got !== want)
                report($sformatf("out_pixel %h, wanted %h", got, want));
        end
    endtask
endclass

module srgb_alpha_blend_pixel_test;

    localparam bit MODE_SRGB   = 1'b0;
    localparam bit MODE_LINEAR = 1'b1;
    localparam int SRC_MAX     = (1 << sabp_pkg::SRC_W) - 1;
    localparam int UNITY       = 1 << sabp_pkg::FRAC_BITS;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic                        cfg_wr_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [sabp_pkg::PIX_W-1:0]  dst_pixel;
    logic [sabp_pkg::SRC_W-1:0]  src_red;
    logic [sabp_pkg::SRC_W-1:0]  src_green;
    logic [sabp_pkg::SRC_W-1:0]  src_blue;
    logic [sabp_pkg::SRC_W-1:0]  src_alpha;
    logic                        out_valid;
    logic                        out_ready;
    logic [sabp_pkg::PIX_W-1:0]  out_pixel;

    pixel_blend_checker pixel_model;
    bit steady;

    srgb_alpha_blend_pixel dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .dst_pixel   (dst_pixel),
        .src_red     (src_red),
        .src_green   (src_green),
        .src_blue    (src_blue),
        .src_alpha   (src_alpha),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_pixel   (out_pixel)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit take_pause();
        return !steady && ($urandom_range(99) < 17);
    endfunction

    always @(negedge clk)
    begin
        out_ready = !take_pause();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pixel_model.note_word('{dst: dst_pixel, red: src_red, green: src_green,
                                        blue: src_blue, alpha: src_alpha});
            if (out_valid && out_ready)
                pixel_model.check_word(out_pixel);
        end
    end

    task automatic send_word(input logic [sabp_pkg::PIX_W-1:0] dst,
                             input int r, input int g, input int b, input int a);
        @(negedge clk);
        while (take_pause())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        dst_pixel = dst;
        src_red   = sabp_pkg::SRC_W'(r);
        src_green = sabp_pkg::SRC_W'(g);
        src_blue  = sabp_pkg::SRC_W'(b);
        src_alpha = sabp_pkg::SRC_W'(a);
        in_valid  = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        int spare;
        spare = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (pixel_model.expected_pixels.size() != 0 && spare < 5000)
        begin
            @(posedge clk);
            spare++;
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic set_mode(input bit m);
        drain();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        pixel_model.linear_mode = m;
    endtask

    task automatic send_corners();
        send_word(32'h0000_0000, UNITY, UNITY, UNITY, 0);
        send_word(32'hFFFF_FFFF, SRC_MAX, SRC_MAX, SRC_MAX, 16);
        send_word(32'h1234_5678, 100, 2000, 4000, 17);
        send_word(32'h8040_2010, 0, 0, 0, UNITY / 2);
        send_word(32'hFF00_FF00, UNITY, UNITY, UNITY, UNITY - 1);
        send_word(32'h00FF_00FF, SRC_MAX, SRC_MAX, SRC_MAX, UNITY);
        send_word(32'hA5A5_A5A5, 0, 1, UNITY - 1, 4112);
        send_word(32'h0000_0000, UNITY, UNITY, UNITY, 4113);
        send_word(32'hFFFF_FFFF, 0, 0, 0, SRC_MAX);
        send_word(32'h0A0B_0C0D, 10, 20, 30, 1000);
        send_word(32'hFF00_0000, SRC_MAX, SRC_MAX, SRC_MAX, SRC_MAX);
        send_word(32'h7F7F_7F7F, SRC_MAX, SRC_MAX, SRC_MAX, 1);
    endtask

    function automatic int pick_colour();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return $urandom_range(UNITY);
        if (roll < 90)
            return $urandom_range(1) ? UNITY : 0;
        return $urandom_range(SRC_MAX);
    endfunction

    task automatic send_random();
        int unsigned roll;
        int a;
        roll = $urandom_range(99);
        if (roll < 15)
            a = $urandom_range(16);
        else if (roll < 30)
            a = $urandom_range(4112, UNITY);
        else if (roll < 85)
            a = $urandom_range(UNITY - 1, 17);
        else
            a = $urandom_range(SRC_MAX, 4113);
        send_word($urandom, pick_colour(), pick_colour(), pick_colour(), a);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid    = 1'b0;
        dst_pixel   = '0;
        src_red     = '0;
        src_green   = '0;
        src_blue    = '0;
        src_alpha   = '0;
        out_ready   = 1'b0;
        steady      = 1'b0;
        pixel_model = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_mode(MODE_SRGB);
        send_corners();
        set_mode(MODE_LINEAR);
        send_corners();

        for (int phase = 0; phase < 4; phase++)
        begin
            set_mode((phase % 2) ? MODE_LINEAR : MODE_SRGB);
            steady = (phase == 2);
            repeat (500) send_random();
        end
        steady = 1'b0;

        drain();
        if (pixel_model.expected_pixels.size() != 0)
            pixel_model.report($sformatf("%0d words never came out",
                                         pixel_model.expected_pixels.size()));
        if (pixel_model.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sabp_pkg.sv
sv/sabp_decode.sv
sv/sabp_mix.sv
sv/sabp_encode.sv
sv/srgb_alpha_blend_pixel.sv
test/srgb_alpha_blend_pixel_test.sv
